// File: hdl/ddwsc_pkg.sv
// shared types, constants and helpers of the wheel speed controller
`timescale 1ns / 1ps
package ddwsc_pkg;

	localparam int COUNT_WRAP_DEF = 32768;

	localparam int TGT_W   = 14;
	localparam int CNT_W   = 15;
	localparam int SINCE_W = 24;
	localparam int AGE_W   = 32;
	localparam int DELTA_W = 16;
	localparam int GAIN_W  = 16;
	localparam int TMO_W   = 20;
	localparam int EL_W    = 20;
	localparam int DUTY_W  = 8;
	localparam int NUM_W   = 44;
	localparam int DEN_W   = 26;
	localparam int PROD_W  = 43;
	localparam int AE_W    = 42;
	localparam int G_W     = 41;
	localparam int ACC_W   = 50;
	localparam int T_W     = 48;
	localparam int FIFO_DEPTH = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int S_DATA_W   = 80;
	localparam int M_DATA_W   = 56;

	localparam logic [27:0] SPEED_K   = 28'd174281250;
	localparam logic [19:0] RATE_K    = 20'd1000000;
	localparam logic [9:0]  US_PER_MS = 10'd1000;
	// reciprocal of 50 in 2^-26 units, exact below 2^20
	localparam logic [20:0] DIV50_K   = 21'd1342178;
	localparam int          DIV50_SH  = 26;
	localparam logic [CNT_W-1:0] WRAP_HI = 15'd32000;
	localparam logic [CNT_W-1:0] WRAP_LO = 15'd1400;
	localparam logic [DUTY_W-1:0] IDLE_DUTY = 8'd25;
	localparam logic [DUTY_W-1:0] SAT_DUTY  = 8'd200;
	localparam logic [TMO_W-1:0]  TMO_RESET = 20'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT_KP  = 3'd0,
		CFG_LEFT_KD  = 3'd1,
		CFG_RIGHT_KP = 3'd2,
		CFG_RIGHT_KD = 3'd3,
		CFG_TIMEOUT  = 3'd4,
		CFG_TMO_OFF  = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		ACT_COMMAND = 1'b0,
		ACT_TICK    = 1'b1
	} action_t;

	typedef struct packed {
		logic [GAIN_W-1:0] left_prop_gain;
		logic [GAIN_W-1:0] left_rate_gain;
		logic [GAIN_W-1:0] right_prop_gain;
		logic [GAIN_W-1:0] right_rate_gain;
		logic [TMO_W-1:0]  command_timeout_ms;
		logic              timeout_off;
	} cfg_t;

	typedef struct packed {
		action_t                action;
		logic signed [11:0]     linear_speed;
		logic signed [15:0]     turn_rate;
		logic [CNT_W-1:0]       left_count;
		logic [CNT_W-1:0]       right_count;
		logic                   left_dir_flag;
		logic                   right_dir_flag;
		logic [EL_W-1:0]        elapsed_us;
	} item_t;

	// first field sits lowest, so it is declared last
	typedef struct packed {
		logic                      timed_out;
		logic signed [DELTA_W-1:0] right_delta;
		logic signed [DELTA_W-1:0] left_delta;
		logic [DUTY_W-1:0]         right_duty;
		logic                      right_forward;
		logic                      right_enable;
		logic [DUTY_W-1:0]         left_duty;
		logic                      left_forward;
		logic                      left_enable;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD_L,
		ST_CMD_LW,
		ST_CMD_R,
		ST_CMD_RW,
		ST_TICK,
		ST_W_SETUP,
		ST_W_SPD,
		ST_W_SPDW,
		ST_W_ERR,
		ST_W_GAIN,
		ST_W_MUL,
		ST_W_CMP,
		ST_W_PWMW,
		ST_W_NEXT,
		ST_OUT
	} back_state_t;

	function automatic logic signed [DELTA_W-1:0] count_delta(
		input logic [CNT_W-1:0] now,
		input logic [CNT_W-1:0] last,
		input logic             dir,
		input logic [16:0]      wrap
	);
		logic signed [17:0] d;
		logic [17:0]        mag;
		logic [CNT_W-1:0]   m15;
		d   = '0;
		mag = '0;
		if (now == last) begin
			mag = '0;
		end else if (last > now && last > WRAP_HI && now < WRAP_LO) begin
			d   = $signed({1'b0, wrap}) - $signed({3'b0, last});
			mag = (d < 0 ? 18'(-d) : 18'(d)) + {3'b0, now};
		end else begin
			d   = $signed({3'b0, now}) - $signed({3'b0, last});
			mag = d < 0 ? 18'(-d) : 18'(d);
		end
		m15 = (mag > 18'd32767) ? 15'h7fff : mag[CNT_W-1:0];
		return dir ? $signed({1'b0, m15}) : -$signed({1'b0, m15});
	endfunction

endpackage

// File: hdl/ddwsc_front.sv
// input side: unpacks stream transfers into items and queues them
`timescale 1ns / 1ps
module ddwsc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [ddwsc_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  logic                         s_axis_tuser,
	output logic                         q_valid,
	output ddwsc_pkg::item_t             q_item,
	input  logic                         q_pop
);
	import ddwsc_pkg::*;

	item_t      mem_q [FIFO_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      in_item;
	logic       push;
	logic       pop;

	always_comb begin
		in_item.action         = action_t'(s_axis_tuser);
		in_item.linear_speed   = $signed(s_axis_tdata[11:0]);
		in_item.turn_rate      = $signed(s_axis_tdata[27:12]);
		in_item.left_count     = s_axis_tdata[42:28];
		in_item.right_count    = s_axis_tdata[57:43];
		in_item.left_dir_flag  = s_axis_tdata[58];
		in_item.right_dir_flag = s_axis_tdata[59];
		in_item.elapsed_us     = s_axis_tdata[79:60];
	end

	assign s_axis_tready = (cnt_q != 2'(FIFO_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != 2'd0);
	assign pop           = q_pop && q_valid;
	assign q_item        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: hdl/ddwsc_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ddwsc_div #(
	parameter int NUM_W = ddwsc_pkg::NUM_W,
	parameter int DEN_W = ddwsc_pkg::DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quot  = num_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/ddwsc_back.sv
// execution side: command targets, tick bookkeeping and per-wheel control
`timescale 1ns / 1ps
module ddwsc_back #(
	parameter int COUNT_WRAP = ddwsc_pkg::COUNT_WRAP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ddwsc_pkg::cfg_t     cfg,
	input  logic                q_valid,
	input  ddwsc_pkg::item_t    q_item,
	output logic                q_pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output ddwsc_pkg::result_t  res
);
	import ddwsc_pkg::*;

	localparam logic [16:0] WRAP_V = 17'(COUNT_WRAP);

	back_state_t state_q, state_nx;

	item_t                      item_q;
	logic signed [TGT_W-1:0]    left_target_q, right_target_q;
	logic [CNT_W-1:0]           left_last_q, right_last_q;
	logic [SINCE_W-1:0]         left_since_q, right_since_q;
	logic [AGE_W-1:0]           age_q;
	logic                       wheel_q;
	logic [SINCE_W-1:0]         dt_q;
	logic [PROD_W-1:0]          prod_q;
	logic [AE_W-1:0]            ae_q;
	logic [39:0]                kpdt_q;
	logic [G_W-1:0]             g_q;
	logic [ACC_W-1:0]           acc_q;
	logic                       ovf_q;
	logic [5:0]                 mcnt_q;
	result_t                    build_q;
	result_t                    out_q;
	logic                       out_valid_q;

	logic                       div_start;
	logic [NUM_W-1:0]           div_num;
	logic [DEN_W-1:0]           div_den;
	logic                       div_done;
	logic [NUM_W-1:0]           div_quot;
	logic                       out_load;

	logic signed [19:0]         lin_x, ang_x, n_left, n_right;
	logic [18:0]                n_left_abs, n_right_abs;
	logic [TGT_W-1:0]           cmd_quot;
	logic signed [TGT_W-1:0]    cur_target;
	logic signed [DELTA_W-1:0]  cur_delta;
	logic [SINCE_W-1:0]         cur_since;
	logic [GAIN_W-1:0]          cur_kp, cur_kd;
	logic [CNT_W-1:0]           cur_delta_abs;
	logic [32:0]                age_sum;
	logic [AGE_W-1:0]           age_sat;
	logic [29:0]                tmo_us;
	logic                       fire;
	logic [SINCE_W:0]           lsince_sum, rsince_sum;
	logic signed [NUM_W-1:0]    err, meas;
	logic [ACC_W-1:0]           acc_nx;
	logic [T_W-1:0]             t_lim;
	logic                       pwm_sat;

	ddwsc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		lin_x       = 20'(item_q.linear_speed);
		ang_x       = 20'(item_q.turn_rate);
		n_left      = lin_x * 20'sd50 - ang_x * 20'sd7;
		n_right     = lin_x * 20'sd50 + ang_x * 20'sd7;
		n_left_abs  = n_left  < 0 ? 19'(-n_left)  : 19'(n_left);
		n_right_abs = n_right < 0 ? 19'(-n_right) : 19'(n_right);
		cmd_quot    = prod_q[DIV50_SH +: TGT_W];

		cur_target = wheel_q ? right_target_q : left_target_q;
		cur_delta  = wheel_q ? build_q.right_delta : build_q.left_delta;
		cur_since  = wheel_q ? right_since_q : left_since_q;
		cur_kp     = wheel_q ? cfg.right_prop_gain : cfg.left_prop_gain;
		cur_kd     = wheel_q ? cfg.right_rate_gain : cfg.left_rate_gain;
		cur_delta_abs = cur_delta < 0 ? CNT_W'(-cur_delta) : CNT_W'(cur_delta);

		age_sum = {1'b0, age_q} + 33'(item_q.elapsed_us);
		age_sat = age_sum[32] ? '1 : age_sum[AGE_W-1:0];
		tmo_us  = 30'(cfg.command_timeout_ms) * 30'(US_PER_MS);
		fire    = !cfg.timeout_off && (age_sat > 32'(tmo_us));
		lsince_sum = {1'b0, left_since_q}  + 25'(item_q.elapsed_us);
		rsince_sum = {1'b0, right_since_q} + 25'(item_q.elapsed_us);

		meas = cur_delta < 0 ? -$signed(div_quot) : $signed(div_quot);
		err  = (NUM_W'(cur_target) <<< 8) - meas;

		acc_nx  = {acc_q[ACC_W-2:0], 1'b0} + (ae_q[mcnt_q] ? ACC_W'(g_q) : '0);
		t_lim   = {dt_q, 24'd0};
		pwm_sat = ovf_q || (acc_q >= ACC_W'(t_lim));
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_nx = (q_item.action == ACT_TICK) ? ST_TICK : ST_CMD_L;
				end
			end
			ST_CMD_L:   state_nx = ST_CMD_LW;
			ST_CMD_LW:  state_nx = ST_CMD_R;
			ST_CMD_R:   state_nx = ST_CMD_RW;
			ST_CMD_RW:  state_nx = ST_IDLE;
			ST_TICK:    state_nx = ST_W_SETUP;
			ST_W_SETUP: state_nx = (cur_target == '0) ? ST_W_NEXT : ST_W_SPD;
			ST_W_SPD:   state_nx = ST_W_SPDW;
			ST_W_SPDW:  if (div_done) state_nx = ST_W_ERR;
			ST_W_ERR:   state_nx = ST_W_GAIN;
			ST_W_GAIN:  state_nx = ST_W_MUL;
			ST_W_MUL:   if (mcnt_q == '0) state_nx = ST_W_CMP;
			ST_W_CMP:   state_nx = pwm_sat ? ST_W_NEXT : ST_W_PWMW;
			ST_W_PWMW:  if (div_done) state_nx = ST_W_NEXT;
			ST_W_NEXT:  state_nx = wheel_q ? ST_OUT : ST_W_SETUP;
			ST_OUT:     if (!out_valid_q || m_axis_tready) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_W_SPD: begin
				div_start = 1'b1;
				div_num   = NUM_W'(prod_q);
				div_den   = {dt_q, 2'b00};
			end
			ST_W_CMP: begin
				div_start = !pwm_sat;
				div_num   = NUM_W'(acc_q[T_W-1:16]);
				div_den   = DEN_W'(dt_q);
			end
			ST_OUT:  out_load = !out_valid_q || m_axis_tready;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		case (state_q)
			ST_CMD_L: prod_q <= PROD_W'(n_left_abs) * PROD_W'(DIV50_K);
			ST_CMD_R: prod_q <= PROD_W'(n_right_abs) * PROD_W'(DIV50_K);
			ST_TICK: begin
				wheel_q             <= 1'b0;
				build_q.timed_out   <= fire;
				build_q.left_delta  <= count_delta(item_q.left_count, left_last_q,
					item_q.left_dir_flag, WRAP_V);
				build_q.right_delta <= count_delta(item_q.right_count, right_last_q,
					item_q.right_dir_flag, WRAP_V);
			end
			ST_W_SETUP: begin
				dt_q   <= (cur_since == '0) ? SINCE_W'(1) : cur_since;
				prod_q <= PROD_W'(cur_delta_abs) * PROD_W'(SPEED_K);
				if (wheel_q) begin
					build_q.right_enable  <= (cur_target != '0);
					build_q.right_forward <= !(cur_target < 0);
					build_q.right_duty    <= IDLE_DUTY;
				end else begin
					build_q.left_enable  <= (cur_target != '0);
					build_q.left_forward <= !(cur_target < 0);
					build_q.left_duty    <= IDLE_DUTY;
				end
			end
			ST_W_ERR: begin
				ae_q   <= err < 0 ? AE_W'(-err) : AE_W'(err);
				kpdt_q <= 40'(cur_kp) * 40'(dt_q);
			end
			ST_W_GAIN: begin
				g_q    <= G_W'(kpdt_q) + G_W'(cur_kd) * G_W'(RATE_K);
				acc_q  <= '0;
				ovf_q  <= 1'b0;
				mcnt_q <= 6'(AE_W - 1);
			end
			ST_W_MUL: begin
				acc_q  <= acc_nx;
				ovf_q  <= ovf_q || (acc_nx[ACC_W-1:T_W] != '0);
				mcnt_q <= mcnt_q - 1'b1;
			end
			ST_W_CMP: begin
				if (pwm_sat) begin
					if (wheel_q) build_q.right_duty <= SAT_DUTY;
					else         build_q.left_duty  <= SAT_DUTY;
				end
			end
			ST_W_PWMW: begin
				if (div_done) begin
					if (wheel_q) build_q.right_duty <= div_quot[DUTY_W-1:0];
					else         build_q.left_duty  <= div_quot[DUTY_W-1:0];
				end
			end
			ST_W_NEXT: wheel_q <= 1'b1;
			default: ;
		endcase
		if (out_load) begin
			out_q <= build_q;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_target_q  <= '0;
			right_target_q <= '0;
			left_last_q    <= '0;
			right_last_q   <= '0;
			left_since_q   <= '0;
			right_since_q  <= '0;
			age_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_CMD_L: age_q <= '0;
				ST_CMD_LW: left_target_q  <= n_left < 0 ? -cmd_quot : cmd_quot;
				ST_CMD_RW: right_target_q <= n_right < 0 ? -cmd_quot : cmd_quot;
				ST_TICK: begin
					age_q         <= fire ? '0 : age_sat;
					left_last_q   <= item_q.left_count;
					right_last_q  <= item_q.right_count;
					left_since_q  <= lsince_sum[SINCE_W] ? '1 : lsince_sum[SINCE_W-1:0];
					right_since_q <= rsince_sum[SINCE_W] ? '1 : rsince_sum[SINCE_W-1:0];
					if (fire) begin
						left_target_q  <= '0;
						right_target_q <= '0;
					end
				end
				ST_W_SETUP: begin
					if (cur_target != '0) begin
						if (wheel_q) right_since_q <= '0;
						else         left_since_q  <= '0;
					end
				end
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign res           = out_q;

endmodule

// File: hdl/diff_drive_wheel_speed_controller_unit.sv
// top level of the differential drive wheel speed controller
// sequence: a command sets both wheel targets; a tick does its bookkeeping, then per active
//   wheel a speed divide, a shift-add multiply and, unless saturated, a duty divide
// throughput: one item at a time in the back end; an idle wheel skips its steps;
//   a 2-entry queue lets input transfers continue meanwhile
// reset: clears targets, counts, timers, queue and output; gains 0, timeout 10000 ms
`timescale 1ns / 1ps
module diff_drive_wheel_speed_controller_unit #(
	parameter int COUNT_WRAP = ddwsc_pkg::COUNT_WRAP_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// linear_speed, turn_rate, left_count, right_count, left_dir_flag,
	// right_dir_flag, elapsed_us
	input  logic [ddwsc_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// action
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// left_enable, left_forward, left_duty, right_enable, right_forward,
	// right_duty, left_delta, right_delta, timed_out
	output logic [ddwsc_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [ddwsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ddwsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ddwsc_pkg::*;

	cfg_t    cfg_q;
	logic    q_valid;
	item_t   q_item;
	logic    q_pop;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_prop_gain     <= '0;
			cfg_q.left_rate_gain     <= '0;
			cfg_q.right_prop_gain    <= '0;
			cfg_q.right_rate_gain    <= '0;
			cfg_q.command_timeout_ms <= TMO_RESET;
			cfg_q.timeout_off        <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LEFT_KP:  cfg_q.left_prop_gain     <= cfg_data[GAIN_W-1:0];
				CFG_LEFT_KD:  cfg_q.left_rate_gain     <= cfg_data[GAIN_W-1:0];
				CFG_RIGHT_KP: cfg_q.right_prop_gain    <= cfg_data[GAIN_W-1:0];
				CFG_RIGHT_KD: cfg_q.right_rate_gain    <= cfg_data[GAIN_W-1:0];
				CFG_TIMEOUT:  cfg_q.command_timeout_ms <= cfg_data[TMO_W-1:0];
				CFG_TMO_OFF:  cfg_q.timeout_off        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ddwsc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	ddwsc_back #(.COUNT_WRAP(COUNT_WRAP)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.res           (res)
	);

	assign m_axis_tdata = {(M_DATA_W - $bits(result_t))'(0), res};

endmodule

// File: hdl/ddwsc_checker.sv
// port-level checks of the wheel speed controller and their binding
`timescale 1ns / 1ps
module ddwsc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ddwsc_pkg::M_DATA_W-1:0] m_axis_tdata
);
	import ddwsc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_left_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[1] && m_axis_tdata[9:2] == IDLE_DUTY)
		else $error("left wheel idle output wrong");

	a_right_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[10]
		|-> m_axis_tdata[11] && m_axis_tdata[19:12] == IDLE_DUTY)
		else $error("right wheel idle output wrong");

endmodule

bind diff_drive_wheel_speed_controller_unit ddwsc_checker u_ddwsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: bench/tb_diff_drive_wheel_speed_controller_unit.sv
// self-checking testbench of the differential drive wheel speed controller
`timescale 1ns / 1ps
module tb_diff_drive_wheel_speed_controller_unit;
	import ddwsc_pkg::*;

	class wheel_speed_scoreboard;
		longint unsigned kp_l, kd_l, kp_r, kd_r, tmo_ms;
		bit tmo_off;
		int tgt_l, tgt_r;
		int unsigned last_l, last_r, since_l, since_r, age_us;
		result_t pending_results[$];
		int fails;

		function new();
			kp_l = 0; kd_l = 0; kp_r = 0; kd_r = 0; tmo_ms = 10000; tmo_off = 0;
			tgt_l = 0; tgt_r = 0; last_l = 0; last_r = 0;
			since_l = 0; since_r = 0; age_us = 0; fails = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_LEFT_KP:  kp_l = v[15:0];
				CFG_LEFT_KD:  kd_l = v[15:0];
				CFG_RIGHT_KP: kp_r = v[15:0];
				CFG_RIGHT_KD: kd_r = v[15:0];
				CFG_TIMEOUT:  tmo_ms = v;
				CFG_TMO_OFF:  tmo_off = v[0];
				default: ;
			endcase
		endfunction

		function int div50(longint n);
			longint a;
			a = (n < 0 ? -n : n) / 50;
			return n < 0 ? -int'(a) : int'(a);
		endfunction

		function longint enc_delta(input int unsigned now, inout int unsigned last,
				input bit dir);
			longint mag;
			if (now == last) return 0;
			if (last > now && last > 32000 && now < 1400)
				mag = longint'(COUNT_WRAP_DEF) - longint'(last) + longint'(now);
			else
				mag = longint'(now) > longint'(last) ? longint'(now) - longint'(last)
					: longint'(last) - longint'(now);
			last = now;
			if (mag > 32767) mag = 32767;
			return dir ? mag : -mag;
		endfunction

		function void wheel_drive(input int tgt, input longint d, inout int unsigned since,
				input longint unsigned kp, input longint unsigned kd,
				output logic en, output logic fw, output logic [7:0] duty);
			longint unsigned dt, mq, ae, g, t, mag;
			longint meas, e;
			if (tgt == 0) begin
				en = 0; fw = 1; duty = IDLE_DUTY;
				return;
			end
			dt = since != 0 ? since : 1;
			since = 0;
			mq = longint'(d < 0 ? -d : d) * 64'd174281250 / (4 * dt);
			meas = d < 0 ? -longint'(mq) : longint'(mq);
			e = longint'(tgt) * 256 - meas;
			ae = e < 0 ? -e : e;
			g = kp * dt + kd * 1000000;
			t = dt << 24;
			if (g == 0) mag = 0;
			else if (ae >= (t + g - 1) / g) mag = 256;
			else mag = ae * g / (dt << 16);
			en = 1;
			fw = tgt < 0 ? 0 : 1;
			duty = mag > 255 ? SAT_DUTY : mag[7:0];
		endfunction

		function void note_item(item_t it);
			result_t r;
			longint unsigned a;
			longint dl, dr;
			if (it.action == ACT_COMMAND) begin
				tgt_l = div50(50 * longint'(it.linear_speed) - 7 * longint'(it.turn_rate));
				tgt_r = div50(50 * longint'(it.linear_speed) + 7 * longint'(it.turn_rate));
				age_us = 0;
				return;
			end
			r = '0;
			a = longint'(age_us) + it.elapsed_us;
			age_us = a > 64'hFFFFFFFF ? 32'hFFFFFFFF : a[31:0];
			if (!tmo_off && longint'(age_us) > tmo_ms * 1000) begin
				tgt_l = 0; tgt_r = 0; age_us = 0; r.timed_out = 1;
			end
			dl = enc_delta(it.left_count, last_l, it.left_dir_flag);
			dr = enc_delta(it.right_count, last_r, it.right_dir_flag);
			since_l = since_l + it.elapsed_us > 24'hFFFFFF ? 24'hFFFFFF : since_l + it.elapsed_us;
			since_r = since_r + it.elapsed_us > 24'hFFFFFF ? 24'hFFFFFF : since_r + it.elapsed_us;
			wheel_drive(tgt_l, dl, since_l, kp_l, kd_l, r.left_enable, r.left_forward,
				r.left_duty);
			wheel_drive(tgt_r, dr, since_r, kp_r, kd_r, r.right_enable, r.right_forward,
				r.right_duty);
			r.left_delta = dl[15:0];
			r.right_delta = dr[15:0];
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void check_result(result_t got);
			result_t x;
			if (pending_results.size() == 0) begin
				$display("%t unexpected result %h", $realtime, got);
				fails++;
				return;
			end
			x = pending_results.pop_front();
			if (got.left_enable !== x.left_enable || got.left_forward !== x.left_forward
					|| got.left_duty !== x.left_duty || got.right_enable !== x.right_enable
					|| got.right_forward !== x.right_forward || got.right_duty !== x.right_duty
					|| got.left_delta !== x.left_delta || got.right_delta !== x.right_delta
					|| got.timed_out !== x.timed_out) begin
				$display("%t mismatch expected %h actual %h", $realtime, x, got);
				fails++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [S_DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wheel_speed_scoreboard sb;
	bit gaps_on, stall_on, long_hold;
	logic [14:0] enc_l, enc_r;

	diff_drive_wheel_speed_controller_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(item_t it);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.action;
		s_axis_tdata <= {it.elapsed_us, it.right_dir_flag, it.left_dir_flag, it.right_count,
			it.left_count, it.turn_rate, it.linear_speed};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_cmd(logic [11:0] lin, logic [15:0] ang);
		item_t it;
		it = '0;
		it.action = ACT_COMMAND;
		it.linear_speed = lin;
		it.turn_rate = ang;
		send_item(it);
	endtask

	task automatic send_tick(logic [14:0] lc, logic [14:0] rc, bit ld, bit rd,
			logic [19:0] el);
		item_t it;
		it = '0;
		it.action = ACT_TICK;
		it.left_count = lc;
		it.right_count = rc;
		it.left_dir_flag = ld;
		it.right_dir_flag = rd;
		it.elapsed_us = el;
		send_item(it);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic random_items(int n);
		int k, stp;
		logic [19:0] el;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 25) begin
				send_cmd(12'($urandom), 16'($urandom));
			end else if (k < 30) begin
				send_tick(15'($urandom), 15'($urandom), 1'($urandom), 1'($urandom),
					20'($urandom));
			end else begin
				stp = $urandom_range(0, 800) - 200;
				enc_l = enc_l + stp[14:0];
				stp = $urandom_range(0, 800) - 200;
				enc_r = enc_r + stp[14:0];
				k = $urandom_range(0, 19);
				el = k == 0 ? 20'd0 : k == 1 ? 20'($urandom) : 20'($urandom_range(2000, 20000));
				send_tick(enc_l, enc_r, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, el);
			end
		end
	endtask

	initial begin
		sb = new();
		gaps_on = 1; stall_on = 1; long_hold = 0;
		enc_l = 0; enc_r = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0; s_axis_tuser = 1'b0; s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// timeout reset value fires here on the long ticks
		send_cmd(12'd100, 16'd0);
		repeat (11) send_tick(15'd0, 15'd0, 1, 1, 20'd1000000);
		drain();
		write_reg(CFG_LEFT_KP, 20'd256);
		write_reg(CFG_LEFT_KD, 20'd3);
		write_reg(CFG_RIGHT_KP, 20'd512);
		write_reg(CFG_RIGHT_KD, 20'd1);
		write_reg(CFG_TIMEOUT, 20'd5);
		write_reg(CFG_TMO_OFF, 20'd0);
		send_cmd(12'h7ff, 16'h7fff);
		send_tick(15'd100, 15'd100, 1, 1, 20'd10000);
		send_tick(15'd100, 15'd100, 1, 1, 20'd0);
		send_cmd(12'h800, 16'h8000);
		send_tick(15'd32500, 15'd32767, 0, 0, 20'd1);
		send_tick(15'd100, 15'd0, 1, 0, 20'd3000);
		send_tick(15'd32767, 15'd1399, 0, 1, 20'hFFFFF);
		send_cmd(12'd0, 16'd0);
		send_tick(15'd32001, 15'd5, 1, 1, 20'd4000);
		send_cmd(12'd50, 16'd357);
		send_tick(15'd1, 15'd32767, 1, 1, 20'd2000);
		send_tick(15'd50, 15'd1, 1, 1, 20'd6000);
		enc_l = 15'd50; enc_r = 15'd1;
		random_items(150);
		drain();

		write_reg(CFG_LEFT_KP, 20'hFFFF);
		write_reg(CFG_LEFT_KD, 20'hFFFF);
		write_reg(CFG_RIGHT_KP, 20'hFFFF);
		write_reg(CFG_RIGHT_KD, 20'hFFFF);
		write_reg(CFG_TIMEOUT, 20'hFFFFF);
		write_reg(CFG_TMO_OFF, 20'd1);
		gaps_on = 0; stall_on = 0;
		random_items(60);
		gaps_on = 1; stall_on = 1;
		long_hold = 1;
		random_items(100);
		drain();

		write_reg(CFG_LEFT_KP, 20'd0);
		write_reg(CFG_LEFT_KD, 20'd0);
		write_reg(CFG_RIGHT_KP, 20'd0);
		write_reg(CFG_RIGHT_KD, 20'd0);
		write_reg(CFG_TIMEOUT, 20'd0);
		write_reg(CFG_TMO_OFF, 20'd0);
		random_items(60);
		drain();

		write_reg(CFG_LEFT_KP, 20'($urandom));
		write_reg(CFG_LEFT_KD, 20'($urandom_range(0, 40)));
		write_reg(CFG_RIGHT_KP, 20'($urandom_range(0, 2000)));
		write_reg(CFG_RIGHT_KD, 20'($urandom_range(0, 40)));
		write_reg(CFG_TIMEOUT, 20'd30);
		write_reg(CFG_TMO_OFF, 20'd0);
		random_items(200);
		drain();

		if (sb.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold) begin
				stall = 500;
				long_hold = 0;
			end else begin
				stall = stall_on ? $urandom_range(0, 4) : 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata[$bits(result_t)-1:0]);
			@(negedge clk);
		end
	end
endmodule

// File: sim.f
hdl/ddwsc_pkg.sv
hdl/ddwsc_front.sv
hdl/ddwsc_div.sv
hdl/ddwsc_back.sv
hdl/diff_drive_wheel_speed_controller_unit.sv
hdl/ddwsc_checker.sv
bench/tb_diff_drive_wheel_speed_controller_unit.sv
